// ===== src/pfpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame pool manager package
// Shared types and constants for the frame pool bookkeeping logic.
// ----------------------------------------------------------------------------
`default_nettype none
package pfpm_pkg;
  localparam int POOL_FRAMES = 16;
  localparam int FW = $clog2(POOL_FRAMES);
  localparam int PAGE_W = 31;

  localparam logic [2:0] ACT_FETCH = 3'd0;
  localparam logic [2:0] ACT_UNPIN = 3'd1;
  localparam logic [2:0] ACT_FLUSH = 3'd2;
  localparam logic [2:0] ACT_NEW = 3'd3;
  localparam logic [2:0] ACT_FLUSH_ALL = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Result item, packed with status in the lowest bits.
  typedef struct packed {
    logic last;
    logic [PAGE_W-1:0] write_page;
    logic write_back;
    logic clear_request;
    logic load_request;
    logic [PAGE_W-1:0] result_page;
    logic [3:0] frame;
    logic [1:0] status;
  } result_t;
endpackage
`default_nettype wire

// ===== src/pfpm_lru.sv =====
// ----------------------------------------------------------------------------
// Page frame pool manager LRU list
// Ordered list of unpinned frames; removal shifts one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pfpm_lru (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    append,
  input  wire logic [pfpm_pkg::FW-1:0] append_frame,
  input  wire logic                    remove_start,
  input  wire logic [pfpm_pkg::FW:0]   remove_pos,
  output logic                         busy,
  input  wire logic [pfpm_pkg::FW-1:0] probe_pos,
  output logic [pfpm_pkg::FW-1:0]      probe_frame,
  output logic [pfpm_pkg::FW:0]        count
);
  logic [pfpm_pkg::FW-1:0] order [pfpm_pkg::POOL_FRAMES];
  logic [pfpm_pkg::FW:0]   pos;

  assign probe_frame = order[probe_pos];

  // Append at the tail, or close a gap one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy <= 1'b0;
      pos <= '0;
    end else if (append) begin
      order[count[pfpm_pkg::FW-1:0]] <= append_frame;
      count <= count + 1'b1;
    end else if (remove_start) begin
      busy <= 1'b1;
      pos <= remove_pos;
    end else if (busy) begin
      if (pos + 1'b1 < count) begin
        order[pos[pfpm_pkg::FW-1:0]] <= order[pos[pfpm_pkg::FW-1:0] + 1'b1];
        pos <= pos + 1'b1;
      end else begin
        count <= count - 1'b1;
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/page_frame_pool_manager_core.sv =====
// ----------------------------------------------------------------------------
// Page frame pool manager core
// Frame metadata, lookup scan, victim selection and flush sequencing.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         tdata: action[2:0], page_id[33:3], mark_dirty[34]
// m_axis   out        tdata: status, frame, result_page, load, clear, wb, write_page
//                     tlast: last
// Lookup walks one frame per cycle through a shared compare unit, then the
// LRU search walks the list, and the item passes through execute and result.
// An LRU removal holds the item until the list has shifted its entries.
// Flush all scans one frame per cycle and emits one result per dirty frame.
// rst is synchronous and clears all control and valid state.
// A stalled result holds the sequencer until it is taken.
`default_nettype none
module page_frame_pool_manager_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // action, page_id, mark_dirty
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // status..write_page (71 bits)
  output logic             m_axis_tlast   // last
);
  localparam int N = pfpm_pkg::POOL_FRAMES;
  localparam int FW = pfpm_pkg::FW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_LRUF  = 7'b0000100,
    S_WAITL = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_FALL  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0] action;
  logic [pfpm_pkg::PAGE_W-1:0] page;
  logic mark;
  logic [pfpm_pkg::PAGE_W-1:0] frame_page [N];
  logic [N-1:0] valid, dirty;
  logic [7:0] pin [N];
  logic [FW:0] next_free;
  logic [FW:0] idx;
  logic hit;
  logic [FW-1:0] hit_f;
  logic [FW:0] lru_pos;
  logic lru_found;
  logic [4:0] nres;
  logic after_lru;
  pfpm_pkg::result_t res;
  logic out_last, out_cont;

  logic victim_sel, hit_in_lru;
  logic [FW-1:0] take_f;
  pfpm_pkg::result_t exec_res, fall_res;
  logic more_dirty;

  logic lru_append, lru_rm, lru_busy;
  logic [FW-1:0] lru_af, lru_pf;
  logic [FW:0] lru_cnt;

  pfpm_lru u_lru (
    .clk(clk), .rst(rst), .append(lru_append), .append_frame(lru_af),
    .remove_start(lru_rm), .remove_pos(lru_pos), .busy(lru_busy),
    .probe_pos(idx[FW-1:0]), .probe_frame(lru_pf), .count(lru_cnt)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {1'b0, res[70:0]};
  assign m_axis_tlast = out_last;

  // Victim from the LRU front, or the hit frame found on the list.
  assign victim_sel = (state == S_LRUF) && !hit
                      && (action == pfpm_pkg::ACT_FETCH || action == pfpm_pkg::ACT_NEW)
                      && next_free >= (FW+1)'(N) && lru_cnt != '0 && !after_lru;
  assign hit_in_lru = (state == S_LRUF) && hit && idx < lru_cnt && lru_pf == hit_f;

  // LRU list control.
  always_comb begin
    lru_append = 1'b0;
    lru_af = hit_f;
    lru_rm = victim_sel || (hit_in_lru && action == pfpm_pkg::ACT_FETCH);
    lru_pos = victim_sel ? '0 : idx;
    if (state == S_EXEC && action == pfpm_pkg::ACT_UNPIN && hit && !lru_found
        && (pin[hit_f] <= 8'd1)) lru_append = 1'b1;
  end

  // Result of the execute step and the frame taken on a miss.
  always_comb begin
    take_f = after_lru ? hit_f : next_free[FW-1:0];
    exec_res = '0;
    exec_res.result_page = page;
    case (action)
      pfpm_pkg::ACT_FETCH, pfpm_pkg::ACT_NEW: begin
        if (hit) begin
          exec_res.frame = 4'(hit_f);
        end else if (next_free < (FW+1)'(N) || after_lru) begin
          if (after_lru && valid[take_f] && dirty[take_f]) begin
            exec_res.write_back = 1'b1;
            exec_res.write_page = frame_page[take_f];
          end
          exec_res.frame = 4'(take_f);
          exec_res.load_request = (action == pfpm_pkg::ACT_FETCH);
          exec_res.clear_request = (action == pfpm_pkg::ACT_NEW);
        end else begin
          exec_res.status = pfpm_pkg::ST_FULL;
        end
      end
      pfpm_pkg::ACT_UNPIN: begin
        if (!hit) exec_res.status = pfpm_pkg::ST_ABSENT;
        else exec_res.frame = 4'(hit_f);
      end
      pfpm_pkg::ACT_FLUSH: begin
        if (!hit) exec_res.status = pfpm_pkg::ST_ABSENT;
        else begin
          exec_res.frame = 4'(hit_f);
          exec_res.write_back = 1'b1;
          exec_res.write_page = page;
        end
      end
      default: exec_res.result_page = '0;
    endcase
  end

  // Flush-all result for the frame under the scan index.
  always_comb begin
    more_dirty = 1'b0;
    for (int j = 0; j < N; j++)
      if ((FW+1)'(j) > idx && valid[j] && dirty[j]) more_dirty = 1'b1;
    fall_res = '0;
    fall_res.frame = 4'(idx);
    fall_res.result_page = frame_page[idx[FW-1:0]];
    fall_res.write_back = 1'b1;
    fall_res.write_page = frame_page[idx[FW-1:0]];
  end

  // Sequencer: scan, LRU search, execute, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      dirty <= '0;
      next_free <= '0;
      out_last <= 1'b0;
      for (int i = 0; i < N; i++) pin[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            action <= s_axis_tdata[2:0];
            page <= s_axis_tdata[33:3];
            mark <= s_axis_tdata[34];
            idx <= '0;
            hit <= 1'b0;
            nres <= '0;
            after_lru <= 1'b0;
            state <= (s_axis_tdata[2:0] == pfpm_pkg::ACT_FLUSH_ALL) ? S_FALL : S_LOOK;
          end
        end
        S_LOOK: begin
          if (!hit && valid[idx[FW-1:0]] && frame_page[idx[FW-1:0]] == page
              && action != pfpm_pkg::ACT_NEW) begin
            hit <= 1'b1;
            hit_f <= idx[FW-1:0];
          end
          if (idx == (FW+1)'(N - 1)) begin
            idx <= '0;
            lru_found <= 1'b0;
            state <= S_LRUF;
          end else idx <= idx + 1'b1;
        end
        S_LRUF: begin
          // Locate the hit frame, or the front entry for a victim.
          if (victim_sel) begin
            hit_f <= lru_pf;
            lru_found <= 1'b1;
            after_lru <= 1'b1;
            state <= S_WAITL;
          end else if (hit_in_lru) begin
            lru_found <= 1'b1;
            state <= (action == pfpm_pkg::ACT_FETCH) ? S_WAITL : S_EXEC;
          end else if (idx >= lru_cnt || idx == (FW+1)'(N - 1)) begin
            state <= S_EXEC;
          end else idx <= idx + 1'b1;
        end
        S_WAITL: begin
          if (!lru_busy) state <= S_EXEC;
        end
        S_EXEC: begin
          res <= exec_res;
          out_last <= 1'b1;
          state <= S_OUT;
          case (action)
            pfpm_pkg::ACT_FETCH, pfpm_pkg::ACT_NEW: begin
              if (hit) begin
                if (pin[hit_f] != 8'hFF) pin[hit_f] <= pin[hit_f] + 1'b1;
              end else if (next_free < (FW+1)'(N) || after_lru) begin
                if (!after_lru) next_free <= next_free + 1'b1;
                frame_page[take_f] <= page;
                valid[take_f] <= 1'b1;
                pin[take_f] <= 8'd1;
                dirty[take_f] <= 1'b0;
              end
            end
            pfpm_pkg::ACT_UNPIN: begin
              if (hit) begin
                if (mark) dirty[hit_f] <= 1'b1;
                if (pin[hit_f] != 8'd0) pin[hit_f] <= pin[hit_f] - 1'b1;
              end
            end
            pfpm_pkg::ACT_FLUSH: begin
              if (hit) dirty[hit_f] <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        S_FALL: begin
          // Scan for the next dirty frame, one per cycle.
          if (idx == (FW+1)'(N) || nres == 5'd16) begin
            res <= '0;
            out_last <= 1'b1;
            out_cont <= 1'b0;
            state <= S_OUT;
          end else if (valid[idx[FW-1:0]] && dirty[idx[FW-1:0]]) begin
            dirty[idx[FW-1:0]] <= 1'b0;
            res <= fall_res;
            out_last <= !more_dirty || nres == 5'd15;
            out_cont <= more_dirty && nres != 5'd15;
            nres <= nres + 1'b1;
            idx <= idx + 1'b1;
            state <= S_OUT;
          end else idx <= idx + 1'b1;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            if (action == pfpm_pkg::ACT_FLUSH_ALL && out_cont && !out_last) state <= S_FALL;
            else state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
